// ----- rtl/dpph_pkg.sv -----
package dpph_pkg;

  localparam int unsigned MaxLenDefault = 2048;
  localparam int unsigned HashW = 30;
  localparam int unsigned IdxW  = 12;
  localparam int unsigned SymW  = 8;
  localparam int unsigned FuncW = 2;
  localparam int unsigned StatW = 2;
  localparam int unsigned Lanes = 2;

  typedef logic [HashW-1:0] hash_t;
  typedef logic [Lanes-1:0][HashW-1:0] hash_pair_t;
  typedef logic [Lanes-1:0][HashW:0] mu_pair_t;

  // lane 0: base 37 mod 1000000007, lane 1: base 53 mod 1000000009
  localparam hash_pair_t ModV  = {30'd1000000009, 30'd1000000007};
  localparam hash_pair_t BaseV = {30'd53, 30'd37};
  // Barrett factors floor(2^(2*HashW) / M)
  localparam mu_pair_t MuV = {
    31'((64'd1 << (2 * HashW)) / 64'd1000000009),
    31'((64'd1 << (2 * HashW)) / 64'd1000000007)
  };

  localparam logic [FuncW-1:0] FuncClear  = 2'd0;
  localparam logic [FuncW-1:0] FuncAppend = 2'd1;
  localparam logic [FuncW-1:0] FuncQuery  = 2'd2;

  localparam logic [StatW-1:0] StatOk        = 2'd0;
  localparam logic [StatW-1:0] StatFull      = 2'd1;
  localparam logic [StatW-1:0] StatNotLetter = 2'd2;
  localparam logic [StatW-1:0] StatBadRange  = 2'd3;

  localparam logic [SymW-1:0] SymLow  = 8'd97;
  localparam logic [SymW-1:0] SymHigh = 8'd122;

  typedef enum logic [1:0] {RD_APPEND, RD_QRY_HI, RD_QRY_LO} rd_sel_e;
  typedef enum logic [1:0] {MUL_INIT, MUL_APPEND, MUL_QUERY} mul_sel_e;

  typedef struct packed {
    logic     take_item;
    logic     init_wr;
    logic     init_adv;
    logic     stat_load;
    rd_sel_e  rd_sel;
    logic     mul_go;
    mul_sel_e mul_sel;
    logic     hold_app;
    logic     hold_qry;
    logic     hold_diff;
    logic     app_wr;
    logic     out_load;
    logic     len_clr;
  } cmd_t;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic             stat_ok;
    logic             init_last;
    logic             mul_done;
  } sts_t;

  function automatic hash_t mod_add(input hash_t a, input hash_t b, input hash_t m);
    logic [HashW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[HashW-1:0];
  endfunction

  function automatic hash_t mod_sub(input hash_t a, input hash_t b, input hash_t m);
    logic [HashW:0] s;
    if (a >= b) begin
      s = {1'b0, a} - {1'b0, b};
    end else begin
      s = {1'b0, a} + {1'b0, m} - {1'b0, b};
    end
    return s[HashW-1:0];
  endfunction

endpackage

// ----- rtl/dpph_ram.sv -----
module dpph_ram #(
  parameter int unsigned Width = 30,
  parameter int unsigned Depth = 2049
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/dpph_modmul.sv -----
module dpph_modmul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 go_i,
  input  dpph_pkg::hash_pair_t a_i,
  input  dpph_pkg::hash_pair_t b_i,
  output dpph_pkg::hash_pair_t res_o,
  output logic                 done_o
);
  import dpph_pkg::*;

  logic [3:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], go_i};
    end
  end

  assign done_o = vld_q[3];

  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    logic [2*HashW-1:0] prod_d, prod_q;
    logic [2*HashW+1:0] qprod;
    logic [HashW:0]     quo_q;
    logic [2*HashW:0]   mprod;
    logic [HashW+1:0]   low_q, rem_q, red;
    logic [HashW+1:0]   m1, m2;
    hash_t              res_q;

    assign prod_d = a_i[g] * b_i[g];
    assign qprod  = prod_q[2*HashW-1:HashW-1] * MuV[g];
    assign mprod  = quo_q * ModV[g];
    assign m1     = {2'b00, ModV[g]};
    assign m2     = {1'b0, ModV[g], 1'b0};

    // remainder after the quotient estimate is below three moduli
    always_comb begin
      if (rem_q >= m2) begin
        red = rem_q - m2;
      end else if (rem_q >= m1) begin
        red = rem_q - m1;
      end else begin
        red = rem_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (go_i) begin
        prod_q <= prod_d;
      end
      if (vld_q[0]) begin
        quo_q <= qprod[2*HashW+1:HashW+1];
        low_q <= prod_q[HashW+1:0];
      end
      if (vld_q[1]) begin
        rem_q <= low_q - mprod[HashW+1:0];
      end
      if (vld_q[2]) begin
        res_q <= red[HashW-1:0];
      end
    end

    assign res_o[g] = res_q;
  end

endmodule

// ----- rtl/dpph_dpath.sv -----
module dpph_dpath #(
  parameter int unsigned MaxLen = dpph_pkg::MaxLenDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dpph_pkg::cmd_t               cmd_i,
  output dpph_pkg::sts_t               sts_o,
  input  logic [dpph_pkg::FuncW-1:0]   func_i,
  input  logic [dpph_pkg::SymW-1:0]    symbol_i,
  input  logic [dpph_pkg::IdxW-1:0]    left_index_i,
  input  logic [dpph_pkg::IdxW-1:0]    right_index_i,
  output dpph_pkg::hash_pair_t         hash_o,
  output logic [dpph_pkg::StatW-1:0]   status_o
);
  import dpph_pkg::*;

  localparam int unsigned AddrW = $clog2(MaxLen + 1);
  localparam int unsigned CmpW  = (AddrW > IdxW) ? AddrW : IdxW;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MaxLen);

  logic [FuncW-1:0] func_q;
  logic [SymW-1:0]  sym_q;
  logic [IdxW-1:0]  lidx_q, ridx_q;
  logic [AddrW-1:0] len_q, init_cnt_q;
  logic [StatW-1:0] stat_q, stat_d, out_stat_q;
  logic [CmpW-1:0]  l_ext, r_ext, n_ext;
  logic [AddrW-1:0] pre_raddr, pow_raddr, shift_addr;
  hash_pair_t       mul_a, mul_b, mul_res;
  logic             mul_done;
  logic             hash_keep;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      func_q <= func_i;
      sym_q  <= symbol_i;
      lidx_q <= left_index_i;
      ridx_q <= right_index_i;
    end
    if (cmd_i.stat_load) begin
      stat_q <= stat_d;
    end
    if (cmd_i.out_load) begin
      out_stat_q <= stat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      init_cnt_q <= '0;
    end else begin
      if (cmd_i.len_clr) begin
        len_q <= '0;
      end else if (cmd_i.app_wr) begin
        len_q <= len_q + AddrW'(1);
      end
      if (cmd_i.init_adv) begin
        init_cnt_q <= init_cnt_q + AddrW'(1);
      end
    end
  end

  assign l_ext = CmpW'(lidx_q);
  assign r_ext = CmpW'(ridx_q);
  assign n_ext = CmpW'(len_q);

  always_comb begin
    stat_d = StatOk;
    unique case (func_q)
      FuncAppend: begin
        if (len_q == LastAddr) begin
          stat_d = StatFull;
        end else if (sym_q < SymLow || sym_q > SymHigh) begin
          stat_d = StatNotLetter;
        end
      end
      FuncQuery: begin
        if (l_ext == '0 || l_ext > r_ext || r_ext > n_ext) begin
          stat_d = StatBadRange;
        end
      end
      default: stat_d = StatOk;
    endcase
  end

  // power index that moves the substring to the common reference position
  assign shift_addr = LastAddr + AddrW'(1) - AddrW'(lidx_q);

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_APPEND: begin
        pre_raddr = len_q;
        pow_raddr = len_q + AddrW'(1);
      end
      RD_QRY_HI: begin
        pre_raddr = AddrW'(ridx_q);
        pow_raddr = shift_addr;
      end
      RD_QRY_LO: begin
        pre_raddr = AddrW'(lidx_q - IdxW'(1));
        pow_raddr = shift_addr;
      end
      default: begin
        pre_raddr = len_q;
        pow_raddr = len_q + AddrW'(1);
      end
    endcase
  end

  assign hash_keep = (func_q == FuncQuery) && (stat_q == StatOk);

  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    hash_t            pre_rd, pow_rd, pre_wdata;
    hash_t            hold_a_q, hold_p_q, cur_q, hash_q;
    logic             pre_we;
    logic [AddrW-1:0] pre_waddr;

    assign pre_we    = (cmd_i.init_wr && init_cnt_q == '0) || cmd_i.app_wr;
    assign pre_waddr = cmd_i.app_wr ? len_q + AddrW'(1) : '0;
    assign pre_wdata = cmd_i.app_wr ? mod_add(hold_a_q, mul_res[g], ModV[g]) : '0;

    dpph_ram #(
      .Width(HashW),
      .Depth(MaxLen + 1)
    ) u_pre (
      .clk_i  (clk_i),
      .we_i   (pre_we),
      .waddr_i(pre_waddr),
      .wdata_i(pre_wdata),
      .raddr_i(pre_raddr),
      .rdata_o(pre_rd)
    );

    dpph_ram #(
      .Width(HashW),
      .Depth(MaxLen + 1)
    ) u_pow (
      .clk_i  (clk_i),
      .we_i   (cmd_i.init_wr),
      .waddr_i(init_cnt_q),
      .wdata_i(cur_q),
      .raddr_i(pow_raddr),
      .rdata_o(pow_rd)
    );

    always_comb begin
      unique case (cmd_i.mul_sel)
        MUL_INIT: begin
          mul_a[g] = cur_q;
          mul_b[g] = BaseV[g];
        end
        MUL_APPEND: begin
          mul_a[g] = pow_rd;
          mul_b[g] = HashW'(sym_q[4:0]);
        end
        MUL_QUERY: begin
          mul_a[g] = hold_a_q;
          mul_b[g] = hold_p_q;
        end
        default: begin
          mul_a[g] = cur_q;
          mul_b[g] = BaseV[g];
        end
      endcase
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cur_q <= HashW'(1);
      end else if (cmd_i.init_adv) begin
        cur_q <= mul_res[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.hold_app || cmd_i.hold_qry) begin
        hold_a_q <= pre_rd;
      end else if (cmd_i.hold_diff) begin
        hold_a_q <= mod_sub(hold_a_q, pre_rd, ModV[g]);
      end
      if (cmd_i.hold_qry) begin
        hold_p_q <= pow_rd;
      end
      if (cmd_i.out_load) begin
        hash_q <= hash_keep ? mul_res[g] : '0;
      end
    end

    assign hash_o[g] = hash_q;
  end

  dpph_modmul u_mul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .go_i  (cmd_i.mul_go),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (mul_res),
    .done_o(mul_done)
  );

  assign status_o        = out_stat_q;
  assign sts_o.func      = func_q;
  assign sts_o.stat_ok   = (stat_d == StatOk);
  assign sts_o.init_last = (init_cnt_q == LastAddr);
  assign sts_o.mul_done  = mul_done;

endmodule

// ----- rtl/dpph_ctrl.sv -----
module dpph_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  dpph_pkg::sts_t sts_i,
  output dpph_pkg::cmd_t cmd_o
);
  import dpph_pkg::*;

  localparam logic [3:0] SInitWr   = 4'd0;
  localparam logic [3:0] SInitWait = 4'd1;
  localparam logic [3:0] SIdle     = 4'd2;
  localparam logic [3:0] SDecode   = 4'd3;
  localparam logic [3:0] SAppRd    = 4'd4;
  localparam logic [3:0] SAppWait  = 4'd5;
  localparam logic [3:0] SQryHi    = 4'd6;
  localparam logic [3:0] SQryLo    = 4'd7;
  localparam logic [3:0] SQryMul   = 4'd8;
  localparam logic [3:0] SQryWait  = 4'd9;
  localparam logic [3:0] SFinish   = 4'd10;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      SInitWr: begin
        cmd_o.init_wr = 1'b1;
        if (sts_i.init_last) begin
          state_d = SIdle;
        end else begin
          cmd_o.mul_go  = 1'b1;
          cmd_o.mul_sel = MUL_INIT;
          state_d       = SInitWait;
        end
      end
      SInitWait: begin
        if (sts_i.mul_done) begin
          cmd_o.init_adv = 1'b1;
          state_d        = SInitWr;
        end
      end
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.take_item = 1'b1;
          state_d         = SDecode;
        end
      end
      SDecode: begin
        cmd_o.stat_load = 1'b1;
        if (!sts_i.stat_ok) begin
          state_d = SFinish;
        end else begin
          unique case (sts_i.func)
            FuncAppend: begin
              cmd_o.rd_sel = RD_APPEND;
              state_d      = SAppRd;
            end
            FuncQuery: begin
              cmd_o.rd_sel = RD_QRY_HI;
              state_d      = SQryHi;
            end
            default: state_d = SFinish;
          endcase
        end
      end
      SAppRd: begin
        cmd_o.mul_go   = 1'b1;
        cmd_o.mul_sel  = MUL_APPEND;
        cmd_o.hold_app = 1'b1;
        state_d        = SAppWait;
      end
      SAppWait: begin
        if (sts_i.mul_done) begin
          cmd_o.app_wr = 1'b1;
          state_d      = SFinish;
        end
      end
      SQryHi: begin
        cmd_o.hold_qry = 1'b1;
        cmd_o.rd_sel   = RD_QRY_LO;
        state_d        = SQryLo;
      end
      SQryLo: begin
        cmd_o.hold_diff = 1'b1;
        state_d         = SQryMul;
      end
      SQryMul: begin
        cmd_o.mul_go  = 1'b1;
        cmd_o.mul_sel = MUL_QUERY;
        state_d       = SQryWait;
      end
      SQryWait: begin
        if (sts_i.mul_done) begin
          state_d = SFinish;
        end
      end
      SFinish: begin
        // hold the result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.len_clr  = (sts_i.func == FuncClear);
          state_d        = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SInitWr;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.mul_done |->
      (state_q == SInitWait || state_q == SAppWait || state_q == SQryWait))
    else $error("multiplier finished outside a wait state");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second word taken while one is in work");

  a_finish_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SFinish && out_valid_q && !out_ready_i) |=>
      (state_q == SFinish && out_valid_q))
    else $error("pending result overwritten");

endmodule

// ----- rtl/double_polynomial_prefix_hash.sv -----
// Channel   Handshake                   Payload
// input     in_valid_i / in_ready_o     func_i, symbol_i, left_index_i, right_index_i
// output    out_valid_o / out_ready_i   hash_first_o, hash_second_o, status_o
//
// After reset the power tables are filled one entry at a time through the
// modular multiplier, with in_ready_o low until they are full.
// Appends and queries wait on the four-stage modular multiplier, and a query reads
// its two prefix entries in turn through the single read port of each prefix store.
// One word is in work at a time; the next is taken while a result waits.
module double_polynomial_prefix_hash #(
  parameter int unsigned MaxLen = dpph_pkg::MaxLenDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [dpph_pkg::FuncW-1:0] func_i,
  input  logic [dpph_pkg::SymW-1:0]  symbol_i,
  input  logic [dpph_pkg::IdxW-1:0]  left_index_i,
  input  logic [dpph_pkg::IdxW-1:0]  right_index_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [dpph_pkg::HashW-1:0] hash_first_o,
  output logic [dpph_pkg::HashW-1:0] hash_second_o,
  output logic [dpph_pkg::StatW-1:0] status_o
);
  import dpph_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  hash_pair_t hash_pair;

  dpph_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dpph_dpath #(
    .MaxLen(MaxLen)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .func_i       (func_i),
    .symbol_i     (symbol_i),
    .left_index_i (left_index_i),
    .right_index_i(right_index_i),
    .hash_o       (hash_pair),
    .status_o     (status_o)
  );

  assign hash_first_o  = hash_pair[0];
  assign hash_second_o = hash_pair[1];

endmodule
